// ===== src/indexed_stack_queue_table_core_assert.svh =====
// Assertion macros for the indexed stack/queue table core.
// Included by the top level; no other dependencies.
`ifndef INDEXED_STACK_QUEUE_TABLE_CORE_ASSERT_SVH
`define INDEXED_STACK_QUEUE_TABLE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ISQT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isqt assertion failed");
`define ISQT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isqt assertion failed");
`else
`define ISQT_ASSERT_IMP(label, clk, rst, ante, cons)
`define ISQT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/isqt_pkg.sv =====
// Shared types for the indexed stack/queue table core.
// No dependencies.
package isqt_pkg;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_GET     = 3'd1,
    OP_FIND    = 3'd2,
    OP_DELETE  = 3'd3,
    OP_POP     = 3'd4,
    OP_PEEK    = 3'd5,
    OP_DEQUEUE = 3'd6,
    OP_CLEAR   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_RANGE     = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic               find;
    logic               write_tail;
    logic               shift;
    logic signed [31:0] value;
  } cmd_t;

  // lookup result travelling down the chain
  typedef struct packed {
    logic               hit;
    logic signed [31:0] word;
  } carry_t;

endpackage

// ===== src/isqt_cell.sv =====
// One table slot: holds a word, takes the tail write or its neighbor's word on a shift,
// and passes a registered lookup result to the next cell. Depends on isqt_pkg.
module isqt_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic                 clk,
  input  isqt_pkg::cmd_t       cmd,
  input  logic [IW-1:0]        target,
  input  logic [CW-1:0]        fill,
  input  logic signed [31:0]   next_word,
  output logic signed [31:0]   word,
  input  isqt_pkg::carry_t     carry_in,
  input  logic [IW-1:0]        idx_in,
  output isqt_pkg::carry_t     carry_out,
  output logic [IW-1:0]        idx_out
);
  import isqt_pkg::*;

  logic occupied;
  logic sel;
  logic take;

  always_comb begin
    occupied = CW'(INDEX) < fill;
    sel      = cmd.find ? (word == cmd.value) : (IW'(INDEX) == target);
    take     = !carry_in.hit && occupied && sel;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      carry_out.hit  <= 1'b1;
      carry_out.word <= word;
      idx_out        <= IW'(INDEX);
    end else begin
      carry_out <= carry_in;
      idx_out   <= idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_tail && fill == CW'(INDEX)) begin
      word <= cmd.value;
    end else if (cmd.shift && IW'(INDEX) >= target) begin
      word <= next_word;
    end
  end

endmodule

// ===== src/indexed_stack_queue_table_core.sv =====
// Channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | op, value, slot_index
// out     | output    | out_valid / out_ready | read_value, found_index, status, occupancy
//
// Append, clear and requests rejected on fill level go from idle straight to the result hold.
// Get, find, delete, pop, peek, dequeue first scan while the lookup result walks
// the chain of DEPTH registered cells. One request in flight at a time.
// A waiting result in the output register does not block the next transfer in.
// Reset clears fill level, FSM and output valid; slot contents stay unwritten.
// Depends on isqt_pkg, isqt_cell and the assertion macro header.
`include "indexed_stack_queue_table_core_assert.svh"
module indexed_stack_queue_table_core #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  isqt_pkg::op_t                       op,
  input  logic signed [31:0]                  value,
  input  logic [$clog2(DEPTH)-1:0]            slot_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  read_value,
  output logic [$clog2(DEPTH)-1:0]            found_index,
  output isqt_pkg::status_t                   status,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy
);
  import isqt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  logic [IW-1:0]      scan_cnt;
  op_t                req_op;
  logic signed [31:0] req_value;
  logic [IW-1:0]      req_target;
  status_t            req_status;
  logic [CW-1:0]      fill, fill_next;

  logic               accept;
  logic               commit;
  logic               need_scan;
  status_t            acc_status;
  logic [IW-1:0]      acc_target;
  logic [CW-1:0]      fill_dec;

  cmd_t               cmd;
  carry_t             carry_chain [DEPTH+1];
  logic [IW-1:0]      idx_chain   [DEPTH+1];
  logic signed [31:0] words       [DEPTH];

  assign accept   = in_valid && in_ready;
  assign fill_dec = fill - CW'(1);

  // request check on the current fill level
  always_comb begin
    acc_status = ST_OK;
    acc_target = '0;
    unique case (op)
      OP_APPEND: acc_status = (fill == CW'(DEPTH)) ? ST_FULL : ST_OK;
      OP_GET, OP_DELETE: begin
        acc_status = (CW'(slot_index) >= fill) ? ST_RANGE : ST_OK;
        acc_target = slot_index;
      end
      OP_FIND: acc_status = ST_NOT_FOUND;
      OP_POP, OP_PEEK: begin
        acc_status = (fill == '0) ? ST_EMPTY : ST_OK;
        acc_target = fill_dec[IW-1:0];
      end
      OP_DEQUEUE: acc_status = (fill == '0) ? ST_EMPTY : ST_OK;
      OP_CLEAR:   acc_status = ST_OK;
      default:    acc_status = ST_OK;
    endcase
    need_scan = (op == OP_FIND) ||
                (acc_status == ST_OK && op != OP_APPEND && op != OP_CLEAR);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = need_scan ? S_SCAN : S_HOLD;
        end
      end
      S_SCAN: begin
        if (scan_cnt == IW'(DEPTH - 1)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        commit = !out_valid || out_ready;
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scan_cnt <= '0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= op;
      req_value  <= value;
      req_target <= acc_target;
      req_status <= acc_status;
    end
  end

  // cell chain
  always_comb begin
    cmd.find       = (req_op == OP_FIND);
    cmd.value      = req_value;
    cmd.write_tail = commit && req_op == OP_APPEND && req_status == ST_OK;
    cmd.shift      = commit && req_status == ST_OK &&
                     (req_op == OP_DELETE || req_op == OP_DEQUEUE);
  end

  assign carry_chain[0] = '0;
  assign idx_chain[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = words[g];
    end else begin : g_mid
      assign nbr = words[g+1];
    end
    isqt_cell #(
      .INDEX (g),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .target    (req_target),
      .fill      (fill),
      .next_word (nbr),
      .word      (words[g]),
      .carry_in  (carry_chain[g]),
      .idx_in    (idx_chain[g]),
      .carry_out (carry_chain[g+1]),
      .idx_out   (idx_chain[g+1])
    );
  end

  always_comb begin
    fill_next = fill;
    if (commit && req_status == ST_OK) begin
      unique case (req_op)
        OP_APPEND:                     fill_next = fill + CW'(1);
        OP_DELETE, OP_POP, OP_DEQUEUE: fill_next = fill_dec;
        OP_CLEAR:                      fill_next = '0;
        default:                       fill_next = fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      occupancy <= fill_next;
      if (req_op == OP_FIND) begin
        read_value <= '0;
        if (carry_chain[DEPTH].hit) begin
          found_index <= idx_chain[DEPTH];
          status      <= ST_OK;
        end else begin
          found_index <= '0;
          status      <= req_status;
        end
      end else begin
        found_index <= '0;
        status      <= req_status;
        if (req_status == ST_OK && req_op != OP_APPEND && req_op != OP_CLEAR) begin
          read_value <= carry_chain[DEPTH].word;
        end else begin
          read_value <= '0;
        end
      end
    end
  end

  `ISQT_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CW'(DEPTH))
  `ISQT_ASSERT_NXT(a_fill_held, clk, rst, !commit, $stable(fill))
  `ISQT_ASSERT_NXT(a_append_grows, clk, rst, cmd.write_tail, fill == $past(fill) + CW'(1))

endmodule

// ===== bench/indexed_stack_queue_table_core_tb.sv =====
// Testbench for indexed_stack_queue_table_core: directed and random requests
// checked against a scoreboard that tracks the table contents and fill level.
// Depends on isqt_pkg and the core RTL.
`timescale 1ns / 1ps

module indexed_stack_queue_table_core_tb;
  import isqt_pkg::*;

  localparam int DEPTH       = 64;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 2000000;

  // random mix modes
  localparam int MIX_GROW   = 0;
  localparam int MIX_SHRINK = 1;
  localparam int MIX_EVEN   = 2;

  typedef struct {
    logic signed [31:0] rd;
    logic [5:0]         found;
    status_t            st;
    logic [6:0]         occ;
  } table_result_t;

  class table_scoreboard;
    logic signed [31:0] words[DEPTH];
    int                 fill;
    table_result_t      expected_q[$];
    int                 errors;
    int                 checked;
    int                 op_seen[8];
    int                 status_seen[8];

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // remove the word at pos and close the gap
    function logic signed [31:0] take_slot(int pos);
      logic signed [31:0] w;
      w = words[pos];
      for (int k = pos; k + 1 < fill; k++) words[k] = words[k + 1];
      fill--;
      return w;
    endfunction

    function void note_request(op_t o, logic signed [31:0] v, logic [5:0] idx);
      table_result_t r;
      r.rd = '0;
      r.found = '0;
      r.st = ST_OK;
      case (o)
        OP_APPEND: begin
          if (fill >= DEPTH) r.st = ST_FULL;
          else begin
            words[fill] = v;
            fill++;
          end
        end
        OP_GET: begin
          if (idx >= fill) r.st = ST_RANGE;
          else r.rd = words[idx];
        end
        OP_FIND: begin
          r.st = ST_NOT_FOUND;
          for (int k = 0; k < fill; k++) begin
            if (words[k] == v) begin
              r.found = 6'(k);
              r.st = ST_OK;
              break;
            end
          end
        end
        OP_DELETE: begin
          if (idx >= fill) r.st = ST_RANGE;
          else r.rd = take_slot(idx);
        end
        OP_POP: begin
          if (fill == 0) r.st = ST_EMPTY;
          else begin
            fill--;
            r.rd = words[fill];
          end
        end
        OP_PEEK: begin
          if (fill == 0) r.st = ST_EMPTY;
          else r.rd = words[fill - 1];
        end
        OP_DEQUEUE: begin
          if (fill == 0) r.st = ST_EMPTY;
          else r.rd = take_slot(0);
        end
        default: fill = 0;
      endcase
      r.occ = 7'(fill);
      expected_q.push_back(r);
      op_seen[o]++;
      status_seen[r.st]++;
    endfunction

    function void check_result(logic signed [31:0] rd, logic [5:0] found, status_t st,
                               logic [6:0] occ);
      table_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding (read_value %0d status %0d)",
                 $time, rd, st);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (rd !== e.rd) begin
        errors++;
        $display("%0t: read_value expected %0d actual %0d", $time, e.rd, rd);
      end
      if (found !== e.found) begin
        errors++;
        $display("%0t: found_index expected %0d actual %0d", $time, e.found, found);
      end
      if (st !== e.st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
      end
      if (occ !== e.occ) begin
        errors++;
        $display("%0t: occupancy expected %0d actual %0d", $time, e.occ, occ);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  op_t                op;
  logic signed [31:0] value;
  logic [5:0]         slot_index;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] read_value;
  logic [5:0]         found_index;
  status_t            status;
  logic [6:0]         occupancy;

  table_scoreboard sb = new();
  bit tx_calm = 0;
  bit rx_calm = 0;

  indexed_stack_queue_table_core #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .value(value),
    .slot_index(slot_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .found_index(found_index),
    .status(status),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_APPEND;
    value = '0;
    slot_index = '0;
    out_ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(read_value, found_index, status, occupancy);
  end

  // result side backpressure: mostly short stalls, a few long, calm stretches
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        r = $urandom_range(0, 99);
        if (!rx_calm && r < 20) stall_left = $urandom_range(1, 3);
        else if (!rx_calm && r < 23) stall_left = $urandom_range(15, 50);
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send(input op_t o, input logic signed [31:0] v, input logic [5:0] idx);
    int n;
    op = o;
    value = v;
    slot_index = idx;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(o, v, idx);
    @(negedge clk);
    n = gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      op = op_t'($urandom_range(0, 7));
      value = $urandom;
      slot_index = 6'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 57) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (r < 85) return $signed(32'($urandom_range(0, 6))) - 32'sd3;
    if (sb.fill > 0) return sb.words[$urandom_range(0, sb.fill - 1)];
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (sb.fill > 0 && r < 75) return 6'($urandom_range(0, sb.fill - 1));
    if (sb.fill < DEPTH && r < 90) return 6'($urandom_range(sb.fill, DEPTH - 1));
    return 6'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic op_t pick_op(int mode);
    int w[8];
    int r;
    int acc;
    case (mode)
      MIX_GROW:   w = '{50, 10, 10, 6, 6, 6, 11, 1};
      MIX_SHRINK: w = '{15, 10, 10, 20, 15, 8, 20, 2};
      default:    w = '{30, 12, 12, 10, 10, 8, 16, 2};
    endcase
    r = $urandom_range(0, 99);
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      acc += w[k];
      if (r < acc) return op_t'(k);
    end
    return OP_CLEAR;
  endfunction

  task automatic send_random(int mode);
    op_t o;
    logic signed [31:0] v;
    o = pick_op(mode);
    v = pick_word();
    // find mostly hits a stored word
    if (o == OP_FIND && sb.fill > 0 && $urandom_range(0, 99) < 60)
      v = sb.words[$urandom_range(0, sb.fill - 1)];
    send(o, v, pick_index());
  endtask

  // append until full, then a few rejected appends
  task automatic fill_up();
    while (sb.fill < DEPTH) send(OP_APPEND, pick_word(), 6'($urandom));
    repeat ($urandom_range(1, 3)) send(OP_APPEND, pick_word(), 6'($urandom));
  endtask

  function automatic int total_sent();
    int s;
    s = 0;
    foreach (sb.op_seen[i]) s += sb.op_seen[i];
    return s;
  endfunction

  initial begin
    int mode;
    int mode_left;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table: every reader rejects
    send(OP_POP, 32'sd5, 6'd0);
    send(OP_PEEK, -32'sd1, 6'd63);
    send(OP_DEQUEUE, 32'sh7fff_ffff, 6'd0);
    send(OP_GET, 32'sd0, 6'd0);
    send(OP_DELETE, 32'sh8000_0000, 6'd63);
    send(OP_FIND, 32'sd0, 6'd0);
    // extremes, with a duplicate for first-match find
    send(OP_APPEND, 32'sh8000_0000, 6'd63);
    send(OP_APPEND, 32'sh7fff_ffff, 6'd0);
    send(OP_APPEND, 32'sd0, 6'd21);
    send(OP_APPEND, -32'sd1, 6'd42);
    send(OP_APPEND, 32'sh7fff_ffff, 6'd0);
    send(OP_GET, 32'sd0, 6'd0);
    send(OP_GET, -32'sd1, 6'd4);
    send(OP_GET, 32'sd0, 6'd5);
    send(OP_GET, 32'sd0, 6'd63);
    send(OP_FIND, 32'sh7fff_ffff, 6'd0);
    send(OP_FIND, 32'sd12345, 6'd63);
    send(OP_PEEK, 32'sd0, 6'd0);
    send(OP_DELETE, 32'sd0, 6'd1);
    send(OP_DEQUEUE, 32'sd0, 6'd0);
    send(OP_POP, 32'sd0, 6'd0);
    send(OP_CLEAR, -32'sd1, 6'd63);
    send(OP_PEEK, 32'sd0, 6'd0);
    send(OP_CLEAR, 32'sd0, 6'd0);

    // hold off until the table is quiet, then hit the full case right away
    drain();
    fill_up();

    mode = MIX_GROW;
    mode_left = $urandom_range(30, 120);
    while (total_sent() < ITEM_TARGET) begin
      if (mode_left == 0) begin
        mode = $urandom_range(MIX_GROW, MIX_EVEN);
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 149) == 0) drain();
      if ($urandom_range(0, 299) == 0) fill_up();
      else send_random(mode);
    end
    in_valid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    $display("covered %0d requests: append %0d get %0d find %0d delete %0d pop %0d",
             total_sent(), sb.op_seen[OP_APPEND], sb.op_seen[OP_GET], sb.op_seen[OP_FIND],
             sb.op_seen[OP_DELETE], sb.op_seen[OP_POP]);
    $display("peek %0d dequeue %0d clear %0d; full %0d empty %0d range %0d miss %0d; %0d checked",
             sb.op_seen[OP_PEEK], sb.op_seen[OP_DEQUEUE], sb.op_seen[OP_CLEAR],
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_NOT_FOUND], sb.checked);
    if (sb.expected_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d results outstanding", $time, sb.expected_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/isqt_pkg.sv
src/isqt_cell.sv
src/indexed_stack_queue_table_core.sv
bench/indexed_stack_queue_table_core_tb.sv
